>>> design/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the backlight duty arbiter
// Holds the register map, the configuration bundle, the controller/datapath
// command and status bundles and the duty arithmetic constants.
// ----------------------------------------------------------------------------
package bda_pkg;

  // Output PWM period; a power of two so the duty divide is a plain shift-in
  localparam int PERIOD_LOG2   = 13;
  localparam int PWM_PERIOD    = 1 << PERIOD_LOG2;
  localparam int NEAR_FULL_DIV = 100;
  localparam int PAST_FULL_ADD = 100;

  // Compare value width and its special values
  localparam int DUTY_W = 14;
  localparam logic [DUTY_W-1:0] FULL_DUTY       = DUTY_W'(PWM_PERIOD);
  localparam logic [DUTY_W-1:0] NEAR_FULL_LIMIT = DUTY_W'(PWM_PERIOD - PWM_PERIOD / NEAR_FULL_DIV);
  localparam logic [DUTY_W-1:0] PAST_FULL_DUTY  = DUTY_W'(PWM_PERIOD + PAST_FULL_ADD);

  // Restoring divider: one quotient bit per step, quotient never exceeds the period
  localparam int DIV_STEPS = PERIOD_LOG2 + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYS_ONLY      = 3'd0,
    CFG_ACT_THRESHOLD = 3'd1,
    CFG_ACT_LAG       = 3'd2,
    CFG_OFF_DELAY_MS  = 3'd3,
    CFG_ZERO_HOLD     = 3'd4,
    CFG_CAPTURE_TTL   = 3'd5
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic        sys_only;
    logic [9:0]  activity_threshold;
    logic [15:0] activity_lag;
    logic [7:0]  off_delay_ms;
    logic [7:0]  zero_hold;
    logic [15:0] capture_ttl;
  } cfg_t;

  // One control-loop pass
  typedef struct packed {
    logic        ms_tick;
    logic        new_capture;
    logic [15:0] capture_high;
    logic [15:0] capture_period;
    logic        pwm_pin_level;
    logic        system_enable;
    logic [9:0]  activity_level;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic prep;      // tick, capture load and staleness
    logic decide;    // enable arbitration, defer, divider load
    logic div_step;  // one quotient bit
    logic finish;    // zero hold, duty write, result load
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;      // pass ends without a duty write
    logic full_duty; // forced full duty, no divide needed
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

>>> design/bda_cfg_regs.sv
// ----------------------------------------------------------------------------
// bda_cfg_regs: configuration register file
// Six registers written by index over a valid/ready channel; reads are the
// flat configuration bundle used by the datapath.
// ----------------------------------------------------------------------------
module bda_cfg_regs
  import bda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Decode the index and update one register per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sys_only           <= 1'b0;
      cfg.activity_threshold <= 10'd81;
      cfg.activity_lag       <= 16'd2000;
      cfg.off_delay_ms       <= 8'd200;
      cfg.zero_hold          <= 8'd128;
      cfg.capture_ttl        <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYS_ONLY:      cfg.sys_only           <= cfg_data[0];
        CFG_ACT_THRESHOLD: cfg.activity_threshold <= cfg_data[9:0];
        CFG_ACT_LAG:       cfg.activity_lag       <= cfg_data[15:0];
        CFG_OFF_DELAY_MS:  cfg.off_delay_ms       <= cfg_data[7:0];
        CFG_ZERO_HOLD:     cfg.zero_hold          <= cfg_data[7:0];
        CFG_CAPTURE_TTL:   cfg.capture_ttl        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/bda_ctrl.sv
// ----------------------------------------------------------------------------
// bda_ctrl: pass sequencer
// Walks one pass through prep, decide, the divide steps if needed and finish,
// issuing datapath commands one per cycle unless waiting for input or output.
// ----------------------------------------------------------------------------
module bda_ctrl
  import bda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide    = 1'b1;
        step_cnt_next = '0;
        if (sts.skip || sts.full_duty) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the result register is free
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

>>> design/bda_datapath.sv
// ----------------------------------------------------------------------------
// bda_datapath: loop state, duty divider and result register
// Keeps the capture fraction, activity and defer state, a restoring divider
// for ceil(num * PERIOD / den) and the registered output item.
// ----------------------------------------------------------------------------
module bda_datapath
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  item_t             item_in,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] out_duty,
  output logic              out_enable,
  output logic              out_updated
);

  // Latched pass input
  item_t item;

  // Loop state
  logic [15:0]       duty_num, duty_den, capture_age, activity_count;
  logic              enable_out, defer_active, last_nonzero;
  logic [7:0]        timeout_left, hold_count;
  logic [DUTY_W-1:0] driven;

  // Per-pass decisions
  logic              pass_en, pass_skip, pass_full;

  // Divider
  logic [16:0]       rem;
  logic [DUTY_W-1:0] quo;

  // Prep step values
  logic [7:0]  timeout_dec;
  logic [15:0] num_prep, den_prep, age_prep, age_base;

  // Decide step values
  logic        bad_frac, act_above, en_dec, full_dec, skip_dec, defer_hit;
  logic [15:0] act_count_dec;
  logic [7:0]  timeout_defer;
  logic        defer_dec;

  // Divide step values
  logic        div_ge;
  logic [16:0] div_rem;

  // Finish step values
  logic [DUTY_W-1:0] dc;
  logic              hold_hit, write_duty;

  // Tick, capture load and stale-capture fallback
  always_comb begin
    timeout_dec = timeout_left;
    if (item.ms_tick && timeout_left != 8'd0) begin
      timeout_dec = timeout_left - 8'd1;
    end
    num_prep = item.new_capture ? item.capture_high   : duty_num;
    den_prep = item.new_capture ? item.capture_period : duty_den;
    age_base = item.new_capture ? 16'd0 : capture_age;
    age_prep = age_base;
    if (age_base > cfg.capture_ttl) begin
      num_prep = {15'd0, item.pwm_pin_level};
      den_prep = 16'd1;
    end else if (age_base != 16'hffff) begin
      age_prep = age_base + 16'd1;
    end
  end

  // Enable arbitration and deferred drop
  always_comb begin
    bad_frac      = (duty_den == 16'd0) || (duty_num > duty_den);
    act_above     = item.activity_level > cfg.activity_threshold;
    act_count_dec = activity_count;
    full_dec      = 1'b0;
    en_dec        = 1'b1;
    if (cfg.sys_only) begin
      en_dec = item.system_enable;
    end else if (!item.system_enable) begin
      en_dec = 1'b0;
      if (act_above) begin
        if (activity_count < cfg.activity_lag) begin
          act_count_dec = activity_count + 16'd1;
        end else begin
          full_dec = 1'b1;
          en_dec   = 1'b1;
        end
      end else begin
        act_count_dec = 16'd0;
      end
    end
    defer_hit     = !cfg.sys_only && enable_out && !en_dec && !item.system_enable;
    timeout_defer = defer_active ? timeout_left : cfg.off_delay_ms;
    defer_dec     = defer_active || defer_hit;
    skip_dec      = bad_frac || (defer_hit && timeout_defer != 8'd0);
  end

  // One restoring step: remainder compared against the period fraction
  always_comb begin
    div_ge  = rem >= {1'b0, duty_den};
    div_rem = div_ge ? (rem - {1'b0, duty_den}) : rem;
  end

  // Ceiling duty, zero hold and duty write decision
  always_comb begin
    dc         = pass_full ? FULL_DUTY : (quo + DUTY_W'(rem != 17'd0));
    hold_hit   = !cfg.sys_only && last_nonzero && (hold_count < cfg.zero_hold)
                 && (dc == '0);
    write_duty = !pass_skip && !hold_hit;
  end

  assign sts.skip      = skip_dec;
  assign sts.full_duty = full_dec && !bad_frac;
  assign sts.out_free  = !out_valid || out_ready;

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= item_in;
    end
  end

  // Divider registers; load at decide, shift one bit per step
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      rem <= {1'b0, duty_num};
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= {div_rem[15:0], 1'b0};
      quo <= {quo[DUTY_W-2:0], div_ge};
    end
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_num       <= 16'd0;
      duty_den       <= 16'd1;
      capture_age    <= 16'd0;
      activity_count <= 16'd0;
      enable_out     <= 1'b0;
      defer_active   <= 1'b0;
      timeout_left   <= 8'd0;
      hold_count     <= 8'd0;
      last_nonzero   <= 1'b1;
      driven         <= '0;
      pass_en        <= 1'b0;
      pass_skip      <= 1'b0;
      pass_full      <= 1'b0;
    end else begin
      if (cmd.prep) begin
        timeout_left <= timeout_dec;
        duty_num     <= num_prep;
        duty_den     <= den_prep;
        capture_age  <= age_prep;
      end
      if (cmd.decide) begin
        pass_skip <= skip_dec;
        pass_full <= full_dec;
        pass_en   <= en_dec;
        // A bad fraction leaves everything else untouched
        if (!bad_frac) begin
          activity_count <= act_count_dec;
          if (defer_hit) begin
            defer_active <= defer_dec;
            timeout_left <= timeout_defer;
          end
        end
      end
      if (cmd.finish && !pass_skip) begin
        defer_active <= 1'b0;
        enable_out   <= pass_en;
        if (hold_hit) begin
          hold_count <= hold_count + 8'd1;
        end else begin
          if (!cfg.sys_only && last_nonzero) begin
            hold_count <= 8'd0;
          end
          last_nonzero <= (dc != '0);
          driven       <= (dc > NEAR_FULL_LIMIT) ? PAST_FULL_DUTY : dc;
        end
      end
    end
  end

  // Result register: load on finish, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_updated <= write_duty;
      if (pass_skip) begin
        out_enable <= enable_out;
        out_duty   <= driven;
      end else begin
        out_enable <= pass_en;
        if (write_duty) begin
          out_duty <= (dc > NEAR_FULL_LIMIT) ? PAST_FULL_DUTY : dc;
        end else begin
          out_duty <= driven;
        end
      end
    end
  end

endmodule

>>> design/backlight_duty_arbiter_top.sv
// ----------------------------------------------------------------------------
// backlight_duty_arbiter_top: backlight duty and enable arbiter
// Each input transfer is one control-loop pass; each pass returns one result.
//
// Input stream (s_axis): one pass per transfer: the ms tick, a capture flag
// with captured high time and period of the system PWM, the PWM pin level,
// the system enable and a display activity sample.
// Output stream (m_axis): the compare value for the output PWM generator, the
// backlight enable level and a flag set when the pass wrote a new duty.
// Configuration (cfg_*): one register per transfer, always ready; write only
// while no pass is in flight.
// Timing: a pass that needs the duty divide runs from one input transfer to the
// earliest next one through prep, decide, the steps of a one bit per cycle
// restoring divider, finish, and the idle state that takes the next pass.
// Passes that end early or force full duty skip the divider.
// m_axis_tvalid is set from a register loaded in finish that holds while
// m_axis_tready is low; the next pass runs meanwhile and waits in finish only
// if the result is still held.
// Reset: synchronous; clears loop state and the registers to their defaults
// and empties the output register.
// ----------------------------------------------------------------------------
module backlight_duty_arbiter_top
  import bda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Fields, low bit up: ms_tick, new_capture, capture_high[15:0],
  // capture_period[15:0], pwm_pin_level, system_enable, activity_level[9:0],
  // zero fill
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,
  // Fields, low bit up: duty_cmp[13:0], backlight_enable, duty_updated
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  item_t             item_in;
  cmd_t              cmd;
  sts_t              sts;
  logic [DUTY_W-1:0] out_duty;
  logic              out_enable, out_updated;
  logic [1:0]        unused_fill;

  // Unpack the input item
  assign item_in.ms_tick        = s_axis_tdata[0];
  assign item_in.new_capture    = s_axis_tdata[1];
  assign item_in.capture_high   = s_axis_tdata[17:2];
  assign item_in.capture_period = s_axis_tdata[33:18];
  assign item_in.pwm_pin_level  = s_axis_tdata[34];
  assign item_in.system_enable  = s_axis_tdata[35];
  assign item_in.activity_level = s_axis_tdata[45:36];
  assign unused_fill            = s_axis_tdata[47:46];

  // Pack the result item
  assign m_axis_tdata = {out_updated, out_enable, out_duty};

  bda_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bda_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_in     (item_in),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_duty    (out_duty),
    .out_enable  (out_enable),
    .out_updated (out_updated)
  );

endmodule

>>> verif/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker: loop predictor and result scoreboard for the duty arbiter
// Watches the configuration, input and output channels of the block. Each
// input transfer runs one pass of an independent copy of the control loop.
// The predicted result is queued and compared field by field with the next
// output transfer. The failure count and the number of pending results are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module bda_checker
  import bda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [15:0]           m_axis_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_checked,
  output int                    duty_writes
);
  timeunit 1ns;
  timeprecision 1ps;

  // Input transfer layout, low bit last in the list
  typedef struct packed {
    logic [1:0]  zero_fill;
    logic [9:0]  activity_level;
    logic        system_enable;
    logic        pwm_pin_level;
    logic [15:0] capture_period;
    logic [15:0] capture_high;
    logic        new_capture;
    logic        ms_tick;
  } pass_word_t;

  // Output transfer layout
  typedef struct packed {
    logic        duty_updated;
    logic        backlight_enable;
    logic [13:0] duty_cmp;
  } loop_result_t;

  // Loop registers and state
  cfg_t        regs;
  logic [15:0] duty_num;
  logic [15:0] duty_den;
  logic [15:0] capture_age;
  logic [15:0] activity_count;
  logic [15:0] last_duty;
  logic        enable_out;
  logic        defer_active;
  logic [7:0]  timeout_left;
  logic [7:0]  hold_count;
  logic [13:0] driven_duty;

  loop_result_t pending_results[$];
  int           fail_count;
  int           seen_count;
  int           write_count;

  function automatic void clear_loop();
    regs.sys_only           = 1'b0;
    regs.activity_threshold = 10'd81;
    regs.activity_lag       = 16'd2000;
    regs.off_delay_ms       = 8'd200;
    regs.zero_hold          = 8'd128;
    regs.capture_ttl        = 16'd1000;
    duty_num       = 16'd0;
    duty_den       = 16'd1;
    capture_age    = 16'd0;
    activity_count = 16'd0;
    last_duty      = 16'hffff;
    enable_out     = 1'b0;
    defer_active   = 1'b0;
    timeout_left   = 8'd0;
    hold_count     = 8'd0;
    driven_duty    = 14'd0;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (cfg_idx_t'(idx))
      CFG_SYS_ONLY:      regs.sys_only           = val[0];
      CFG_ACT_THRESHOLD: regs.activity_threshold = val[9:0];
      CFG_ACT_LAG:       regs.activity_lag       = val[15:0];
      CFG_OFF_DELAY_MS:  regs.off_delay_ms       = val[7:0];
      CFG_ZERO_HOLD:     regs.zero_hold          = val[7:0];
      CFG_CAPTURE_TTL:   regs.capture_ttl        = val[15:0];
      default: ;
    endcase
  endfunction

  // One loop pass; returns 1 when the pass writes a new duty
  function automatic logic run_pass(pass_word_t w);
    logic [31:0] dc;
    logic        en;
    logic        active;
    logic        full;
    full = 1'b0;

    // Tick, capture load, then staleness
    if (w.ms_tick && timeout_left != 8'd0)
      timeout_left--;
    if (w.new_capture) begin
      duty_num    = w.capture_high;
      duty_den    = w.capture_period;
      capture_age = 16'd0;
    end
    if (capture_age > regs.capture_ttl) begin
      duty_num = {15'd0, w.pwm_pin_level};
      duty_den = 16'd1;
    end else if (capture_age != 16'hffff) begin
      capture_age++;
    end

    // Zero period or ratio above one: leave everything as is
    if (duty_den == 16'd0 || duty_num > duty_den)
      return 1'b0;

    // Enable arbitration with activity detection
    if (regs.sys_only) begin
      en = w.system_enable;
    end else if (w.system_enable) begin
      en = 1'b1;
    end else begin
      active = w.activity_level > regs.activity_threshold;
      if (!active) begin
        activity_count = 16'd0;
      end else if (activity_count < regs.activity_lag) begin
        activity_count++;
        active = 1'b0;
      end else begin
        full = 1'b1;
      end
      en = active;
    end

    // Defer an enable drop the system did not ask for
    if (!regs.sys_only && enable_out && !en && !w.system_enable) begin
      if (!defer_active) begin
        timeout_left = regs.off_delay_ms;
        defer_active = 1'b1;
      end
      if (timeout_left != 8'd0)
        return 1'b0;
    end

    if (full)
      dc = 32'(PWM_PERIOD);
    else
      dc = (32'(duty_num) * 32'(PWM_PERIOD) + 32'(duty_den) - 32'd1) / 32'(duty_den);
    defer_active = 1'b0;
    enable_out   = en;

    // Hold off a zero duty while the last written duty was nonzero
    if (!regs.sys_only && last_duty != 16'd0) begin
      if (hold_count < regs.zero_hold && dc == 32'd0) begin
        hold_count++;
        return 1'b0;
      end
      hold_count = 8'd0;
    end

    // Push duties near full past the period
    last_duty = dc[15:0];
    if (dc > 32'(PWM_PERIOD - PWM_PERIOD / NEAR_FULL_DIV))
      driven_duty = 14'(PWM_PERIOD + PAST_FULL_ADD);
    else
      driven_duty = dc[13:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] result check: %s", $time, msg);
    fail_count++;
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin : watch
    loop_result_t got;
    loop_result_t want;
    logic         upd;
    if (rst) begin
      clear_loop();
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        write_register(cfg_index, cfg_data);

      // Compare an output transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        seen_count++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no pass pending (data %h)",
                                    seen_count, m_axis_tdata));
        end else begin
          want = pending_results.pop_front();
          if (got.duty_cmp !== want.duty_cmp)
            report_mismatch($sformatf("result %0d: duty_cmp %0d, expected %0d",
                                      seen_count, got.duty_cmp, want.duty_cmp));
          if (got.backlight_enable !== want.backlight_enable)
            report_mismatch($sformatf("result %0d: backlight_enable %b, expected %b",
                                      seen_count, got.backlight_enable, want.backlight_enable));
          if (got.duty_updated !== want.duty_updated)
            report_mismatch($sformatf("result %0d: duty_updated %b, expected %b",
                                      seen_count, got.duty_updated, want.duty_updated));
        end
      end

      // Run the loop on an input transfer and queue the prediction
      if (s_axis_tvalid && s_axis_tready) begin
        upd = run_pass(pass_word_t'(s_axis_tdata));
        if (upd)
          write_count++;
        want.duty_cmp         = driven_duty;
        want.backlight_enable = enable_out;
        want.duty_updated     = upd;
        pending_results.push_back(want);
      end
    end
    mismatches      <= fail_count;
    outstanding     <= pending_results.size();
    results_checked <= seen_count;
    duty_writes     <= write_count;
  end

endmodule

>>> verif/tb_backlight_duty_arbiter_top.sv
// ----------------------------------------------------------------------------
// tb_backlight_duty_arbiter_top: testbench for the backlight duty arbiter
// Drives directed passes, a short capture-age soak and five random phases with
// different register settings and idle patterns, including a long output
// hold-off. A separate checker predicts every result; this top makes the
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_backlight_duty_arbiter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bda_pkg::*;

  localparam int CYCLE_LIMIT     = 2000000;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SOAK_PASSES     = 40;
  localparam int PHASE_PASSES    = 90;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int results_checked;
  int duty_writes;

  int cycle_count   = 0;
  int items_sent    = 0;
  int settings_done = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_left     = 0;
  logic pressure_on   = 1'b0;
  logic pressure_done = 1'b0;

  // Generator state: sticky system enable and activity runs
  logic       sys_level = 1'b1;
  logic       act_busy  = 1'b0;
  logic [9:0] cur_threshold = 10'd81;

  backlight_duty_arbiter_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bda_checker CHK (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .duty_writes     (duty_writes)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("backlight_duty_arbiter_top: mismatch");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off when pressure is asked
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (pressure_on && !pressure_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [47:0] pack_pass(logic tick, logic cap, logic [15:0] hi,
                                            logic [15:0] per, logic pin, logic sys,
                                            logic [9:0] act);
    return {2'b00, act, sys, pin, per, hi, cap, tick};
  endfunction

  function automatic cfg_t make_setting(logic compat, logic [9:0] thr, logic [15:0] lag,
                                        logic [7:0] dly, logic [7:0] hold, logic [15:0] ttl);
    cfg_t s;
    s.sys_only           = compat;
    s.activity_threshold = thr;
    s.activity_lag       = lag;
    s.off_delay_ms       = dly;
    s.zero_hold          = hold;
    s.capture_ttl        = ttl;
    return s;
  endfunction

  // Mostly valid ratios with random content, some zero periods and ratios above one
  function automatic logic [47:0] random_pass();
    logic [15:0] per;
    logic [15:0] hi;
    logic [9:0]  act;
    int          pick;
    per = 16'($urandom);
    if ($urandom_range(3) == 0)
      per = 16'($urandom_range(1, 20));
    pick = $urandom_range(99);
    if (pick < 70)
      hi = 16'($urandom_range(0, int'(per)));
    else if (pick < 78)
      hi = per - 16'($urandom_range(0, int'(per) / 100));
    else if (pick < 84)
      hi = 16'd0;
    else if (pick < 90) begin
      per = 16'd0;
      hi  = 16'($urandom);
    end else if (per != 16'hffff)
      hi = 16'($urandom_range(int'(per) + 1, 65535));
    else
      hi = per;

    if ($urandom_range(99) < 12)
      sys_level = ~sys_level;
    if ($urandom_range(99) < 10)
      act_busy = ~act_busy;
    if ($urandom_range(9) == 0)
      act = 10'($urandom);
    else if (act_busy && cur_threshold != 10'h3ff)
      act = 10'($urandom_range(int'(cur_threshold) + 1, 1023));
    else
      act = 10'($urandom_range(0, int'(cur_threshold)));

    return pack_pass(1'($urandom_range(1)), $urandom_range(99) < 30, hi, per,
                     1'($urandom_range(1)), sys_level, act);
  endfunction

  // Write all six registers back to back, then drop valid
  task automatic program_registers(input cfg_t setting);
    cfg_idx_t              idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{CFG_SYS_ONLY, CFG_ACT_THRESHOLD, CFG_ACT_LAG,
            CFG_OFF_DELAY_MS, CFG_ZERO_HOLD, CFG_CAPTURE_TTL};
    val = '{CFG_DATA_W'(setting.sys_only), CFG_DATA_W'(setting.activity_threshold),
            setting.activity_lag, CFG_DATA_W'(setting.off_delay_ms),
            CFG_DATA_W'(setting.zero_hold), setting.capture_ttl};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_threshold = setting.activity_threshold;
    settings_done++;
  endtask

  // Offer one pass after a random gap and hold it until the transfer
  task automatic send_pass(input logic [47:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_t setting;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad fractions, zero hold, near full, activity, defer, fallback
    program_registers(make_setting(1'b0, 10'd81, 16'd2, 8'd2, 8'd2, 16'd3));
    send_pass(pack_pass(0, 1, 16'd0,     16'd0,     0, 1, 10'd0));
    send_pass(pack_pass(0, 1, 16'hffff,  16'd1,     0, 1, 10'd0));
    send_pass(pack_pass(0, 1, 16'd0,     16'd100,   0, 1, 10'd0));
    send_pass(pack_pass(0, 0, 16'd0,     16'd0,     0, 1, 10'd0));
    send_pass(pack_pass(0, 0, 16'd0,     16'd0,     0, 1, 10'd0));
    send_pass(pack_pass(0, 1, 16'd8150,  16'd8192,  0, 1, 10'd0));
    send_pass(pack_pass(1, 1, 16'hffff,  16'hffff,  1, 1, 10'h3ff));
    send_pass(pack_pass(0, 1, 16'd1,     16'hffff,  0, 1, 10'd0));
    send_pass(pack_pass(0, 1, 16'd8111,  16'd8192,  0, 1, 10'd0));
    send_pass(pack_pass(0, 1, 16'd8112,  16'd8192,  0, 1, 10'd0));
    send_pass(pack_pass(0, 1, 16'd4096,  16'd8192,  0, 0, 10'h3ff));
    send_pass(pack_pass(1, 0, 16'd0,     16'd0,     0, 0, 10'h3ff));
    send_pass(pack_pass(1, 1, 16'd4096,  16'd8192,  0, 0, 10'h3ff));
    send_pass(pack_pass(0, 1, 16'd4096,  16'd8192,  0, 0, 10'd0));
    send_pass(pack_pass(1, 0, 16'd0,     16'd0,     0, 0, 10'd81));
    send_pass(pack_pass(1, 0, 16'd0,     16'd0,     0, 0, 10'd82));
    send_pass(pack_pass(0, 0, 16'd0,     16'd0,     1, 1, 10'd0));
    send_pass(pack_pass(0, 0, 16'd0,     16'd0,     1, 1, 10'd0));
    send_pass(pack_pass(0, 0, 16'd0,     16'd0,     0, 1, 10'h3ff));
    send_pass(pack_pass(0, 0, 16'd0,     16'd0,     0, 1, 10'd0));
    send_pass(pack_pass(0, 0, 16'd0,     16'd0,     1, 0, 10'd0));
    drain();

    // Soak: a never-stale capture keeps aging, then a lower TTL sees it stale
    program_registers(make_setting(1'b0, 10'd81, 16'd2000, 8'd200, 8'd128, 16'hffff));
    send_pass(pack_pass(0, 1, 16'd2, 16'd1, 0, 1, 10'd0));
    for (int n = 0; n < SOAK_PASSES; n++)
      send_pass(pack_pass(1'($urandom_range(1)), 0, 16'd0, 16'd0, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 10'($urandom)));
    drain();
    program_registers(make_setting(1'b0, 10'd81, 16'd2000, 8'd200, 8'd128, 16'd20));
    send_pass(pack_pass(0, 0, 16'd0, 16'd0, 1, 1, 10'd0));
    send_pass(pack_pass(0, 0, 16'd0, 16'd0, 0, 1, 10'd0));
    drain();

    // Random phases: each with its own setting and its own idle or hold-off pattern
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          setting = make_setting(1'b0, 10'd81, 16'd3, 8'd3, 8'd4, 16'd6);
        end
        1: begin
          tx_idle_pct = 58;
          rx_stall_pct <= 0;
          setting = make_setting(1'b1, 10'd0, 16'd0, 8'd0, 8'd0, 16'd0);
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 58;
          setting = make_setting(1'b0, 10'h3ff, 16'hffff, 8'hff, 8'hff, 16'hffff);
        end
        3: begin
          tx_idle_pct = 29;
          rx_stall_pct <= 29;
          setting = make_setting(1'($urandom_range(1)), 10'($urandom),
                                 16'($urandom_range(0, 8)), 8'($urandom_range(0, 6)),
                                 8'($urandom_range(0, 5)), 16'($urandom_range(0, 12)));
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          setting = make_setting(1'b0, 10'd0, 16'd0, 8'd0, 8'd0, 16'd0);
        end
      endcase
      program_registers(setting);
      // Last phase: hold the output off while passes keep coming
      if (ph == 4)
        pressure_on <= 1'b1;
      for (int n = 0; n < PHASE_PASSES; n++)
        send_pass(random_pass());
      drain();
    end

    $display("Covered %0d passes over %0d register settings: directed cases, an age soak,",
             items_sent, settings_done);
    $display("five random phases with idling and a long output hold-off; %0d results, %0d writes",
             results_checked, duty_writes);
    if (mismatches == 0) begin
      $display("backlight_duty_arbiter_top: match");
    end else begin
      $display("backlight_duty_arbiter_top: mismatch");
    end
    $finish;
  end

endmodule
